// File: sv/gbt_pkg.sv
// Shared types, constants and code checks for the GB2312/Big5 table transcoder.
// Used by the design modules and the testbench; depends on nothing.
package gbt_pkg;

    localparam int TABLE_DEPTH_DEF  = 32768;
    localparam int BIG5_ENTRIES_DEF = 13973;
    localparam int GB_ENTRIES_DEF   = 7614;

    // Beat layout of the input channel.
    localparam int TABLE_INDEX_W = 15;
    localparam int TABLE_WORD_W  = 16;
    localparam int BYTE_W        = 8;
    localparam int S_TDATA_W     = 40;

    // Output queue between the table stage and the master side.
    localparam int OUT_FIFO_DEPTH = 8;
    localparam int OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
    localparam int OUT_CNT_W      = OUT_PTR_W + 1;

    localparam logic DIR_GB_TO_BIG5 = 1'b0;
    localparam logic DIR_BIG5_TO_GB = 1'b1;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    localparam logic [7:0] GB_LEAD_LO    = 8'hA1;
    localparam logic [7:0] GB_LEAD_MID   = 8'hA9;
    localparam logic [7:0] GB_LEAD_HANZI = 8'hB0;
    localparam logic [7:0] GB_LEAD_HI    = 8'hF7;
    localparam logic [7:0] GB_ROW_SKIP   = 8'd9;
    localparam logic [7:0] GB_ROW_LEN    = 8'd94;
    localparam logic [7:0] BIG5_LEAD_HI  = 8'hF9;
    localparam logic [7:0] BIG5_ROW_LEN  = 8'd157;
    localparam logic [7:0] BIG5_LOW_LO   = 8'h40;
    localparam logic [7:0] BIG5_LOW_HI   = 8'h7E;
    localparam logic [7:0] BIG5_HIGH_OFS = 8'd63;
    localparam logic [7:0] TRAIL_LO      = 8'hA1;
    localparam logic [7:0] BYTE_INVALID  = 8'hFF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic [1:0] cnt;
        out_beat_t  first;
        out_beat_t  second;
    } fifo_push_t;

    function automatic logic is_lead(input logic dir, input logic [7:0] c);
        logic res;
        if (dir == DIR_GB_TO_BIG5) begin
            res = (c >= GB_LEAD_LO && c <= GB_LEAD_MID) ||
                  (c >= GB_LEAD_HANZI && c <= GB_LEAD_HI);
        end else begin
            res = (c >= GB_LEAD_LO && c <= BIG5_LEAD_HI);
        end
        return res;
    endfunction

endpackage

// File: sv/gbt_pair_decode.sv
// Checks a lead/trail pair and computes its slot in the conversion table.
// Depends on gbt_pkg for the code ranges and the lead check.
module gbt_pair_decode #(
    parameter int TABLE_DEPTH  = gbt_pkg::TABLE_DEPTH_DEF,
    parameter int BIG5_ENTRIES = gbt_pkg::BIG5_ENTRIES_DEF,
    parameter int GB_ENTRIES   = gbt_pkg::GB_ENTRIES_DEF,
    parameter int ADDR_W       = $clog2(TABLE_DEPTH)
) (
    input  logic              direction,
    input  logic [7:0]        c1,
    input  logic [7:0]        c2,
    output logic              pair_ok,
    output logic [ADDR_W-1:0] slot
);
    import gbt_pkg::*;

    logic [7:0]  row;
    logic [7:0]  col;
    logic [7:0]  row_len;
    logic        trail_ok;
    logic [16:0] loc;
    logic [16:0] base;
    logic [16:0] limit;
    logic [16:0] sum;

    always_comb begin
        trail_ok = 1'b0;
        row      = 8'd0;
        col      = 8'd0;
        if (direction == DIR_GB_TO_BIG5) begin
            trail_ok = (c2 >= TRAIL_LO) && (c2 != BYTE_INVALID);
            row      = (c1 <= GB_LEAD_MID) ? (c1 - GB_LEAD_LO)
                                           : (c1 - GB_LEAD_HANZI + GB_ROW_SKIP);
            col      = c2 - TRAIL_LO;
            row_len  = GB_ROW_LEN;
            base     = 17'(BIG5_ENTRIES);
            limit    = 17'(GB_ENTRIES);
        end else begin
            row     = c1 - GB_LEAD_LO;
            row_len = BIG5_ROW_LEN;
            base    = 17'd0;
            limit   = 17'(BIG5_ENTRIES);
            if (c2 >= BIG5_LOW_LO && c2 <= BIG5_LOW_HI) begin
                trail_ok = 1'b1;
                col      = c2 - BIG5_LOW_LO;
            end else if (c2 >= TRAIL_LO && c2 != BYTE_INVALID) begin
                trail_ok = 1'b1;
                col      = c2 - TRAIL_LO + BIG5_HIGH_OFS;
            end
        end
        // One small constant multiply; the row length depends on direction.
        loc     = 17'(row) * 17'(row_len) + 17'(col);
        sum     = base + loc;
        pair_ok = is_lead(direction, c1) && trail_ok && (loc < limit) &&
                  (sum < 17'(TABLE_DEPTH));
        slot    = ADDR_W'(sum);
    end

endmodule

// File: sv/gbt_table_ram.sv
// Conversion table: one write port for loads, one read port with registered data.
// Depends on gbt_pkg for the word width.
module gbt_table_ram #(
    parameter int DEPTH  = gbt_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [ADDR_W-1:0]               wr_addr,
    input  logic [gbt_pkg::TABLE_WORD_W-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [ADDR_W-1:0]               rd_addr,
    output logic [gbt_pkg::TABLE_WORD_W-1:0] rd_data
);
    import gbt_pkg::*;

    logic [TABLE_WORD_W-1:0] mem [DEPTH];
    logic [TABLE_WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/gbt_out_fifo.sv
// Output queue of text bytes: takes up to two beats a cycle, gives one while m_tready is high.
// Depends on gbt_pkg for the beat and push types.
module gbt_out_fifo (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gbt_pkg::fifo_push_t            push,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,
    output logic                           m_tlast,
    output logic [gbt_pkg::OUT_CNT_W-1:0]  count
);
    import gbt_pkg::*;

    out_beat_t              fifo_mem [OUT_FIFO_DEPTH];
    logic [OUT_PTR_W-1:0]   head_reg, head_next;
    logic [OUT_PTR_W-1:0]   tail_reg, tail_next;
    logic [OUT_PTR_W-1:0]   tail_p1;
    logic [OUT_CNT_W-1:0]   count_reg, count_next;
    logic                   pop;

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = fifo_mem[head_reg].data;
    assign m_tlast  = fifo_mem[head_reg].last;
    assign count    = count_reg;
    assign pop      = m_tvalid && m_tready;
    assign tail_p1  = tail_reg + OUT_PTR_W'(1);

    always_comb begin
        head_next  = pop ? head_reg + OUT_PTR_W'(1) : head_reg;
        tail_next  = tail_reg + OUT_PTR_W'(push.cnt);
        count_next = count_reg + OUT_CNT_W'(push.cnt) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            fifo_mem[tail_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            fifo_mem[tail_p1] <= push.second;
        end
    end

endmodule

// File: sv/gb_big5_table_transcoder.sv
// Top level of the GB2312/Big5 byte-stream transcoder.
// Depends on gbt_pkg, gbt_pair_decode, gbt_table_ram and gbt_out_fifo.
//
//   The slave channel carries one beat per item. s_tuser selects the kind:
//   a load beat writes table_word into the table at table_index, a convert
//   beat carries one text byte in data_byte, and s_tlast marks the last byte
//   of a run. A lead byte that does not end a run is held until the next
//   convert beat; the pair then leaves as two master beats, either the table
//   word (high byte first) or the two bytes unchanged. Other bytes leave as
//   one beat. m_tlast marks the final byte produced by one input beat.
//   Throughput: one input beat per cycle while the receiver keeps up.
//   The table is read at the accepting edge into the registered table stage;
//   from there the bytes enter the output queue, which drives m_tvalid.
//   The direction register is written through cfg_wr_en/cfg_wr_data; the
//   user must write it only while the block is idle, which the block does
//   not enforce. Reset clears the held lead, the direction, the pipeline
//   and the output queue; the table must be loaded before use.
//   When the receiver stalls, bytes collect in an eight-entry queue and
//   s_tready drops once the queue and the table stage leave room for fewer
//   than two more bytes.
module gb_big5_table_transcoder #(
    parameter int TABLE_DEPTH  = gbt_pkg::TABLE_DEPTH_DEF,
    parameter int BIG5_ENTRIES = gbt_pkg::BIG5_ENTRIES_DEF,
    parameter int GB_ENTRIES   = gbt_pkg::GB_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,   // direction
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // table_index[14:0], table_word[30:15], data_byte[38:31], zero pad [39]
    input  logic [gbt_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,       // end_of_run
    input  logic                          s_tuser,       // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,       // out_byte
    output logic                          m_tlast        // out_last
);
    import gbt_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic [TABLE_INDEX_W-1:0] table_index;
    logic [TABLE_WORD_W-1:0]  table_word;
    logic [7:0]               data_byte;
    logic                     accept;

    logic                     direction_reg;
    logic [7:0]               held_lead_reg, held_lead_next;
    logic                     lead_pending_reg, lead_pending_next;

    // Table read stage.
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_pair_reg, s1_pair_next;
    logic                     s1_conv_reg, s1_conv_next;
    logic [7:0]               s1_lead_reg, s1_lead_next;
    logic [7:0]               s1_byte_reg, s1_byte_next;

    logic                     pair_ok;
    logic [ADDR_W-1:0]        slot;
    logic                     ram_wr_en;
    logic                     ram_rd_en;
    logic [TABLE_WORD_W-1:0]  ram_rd_data;

    fifo_push_t               push;
    logic [OUT_CNT_W-1:0]     fifo_count;
    logic [1:0]               s1_need;
    logic [OUT_CNT_W:0]       committed;

    assign table_index = s_tdata[TABLE_INDEX_W-1:0];
    assign table_word  = s_tdata[TABLE_INDEX_W +: TABLE_WORD_W];
    assign data_byte   = s_tdata[TABLE_INDEX_W + TABLE_WORD_W +: BYTE_W];

    // Room must remain for what the table stage holds plus two more bytes.
    assign s1_need   = !s1_valid_reg ? 2'd0 : (s1_pair_reg ? 2'd2 : 2'd1);
    assign committed = (OUT_CNT_W + 1)'(fifo_count) + (OUT_CNT_W + 1)'(s1_need);
    assign s_tready  = (committed <= (OUT_CNT_W + 1)'(OUT_FIFO_DEPTH - 2));
    assign accept    = s_tvalid && s_tready;

    assign ram_wr_en = accept && (s_tuser == ACT_LOAD) &&
                       (17'(table_index) < 17'(TABLE_DEPTH));

    gbt_pair_decode #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .BIG5_ENTRIES (BIG5_ENTRIES),
        .GB_ENTRIES   (GB_ENTRIES),
        .ADDR_W       (ADDR_W)
    ) u_decode (
        .direction (direction_reg),
        .c1        (held_lead_reg),
        .c2        (data_byte),
        .pair_ok   (pair_ok),
        .slot      (slot)
    );

    always_comb begin
        held_lead_next    = held_lead_reg;
        lead_pending_next = lead_pending_reg;
        s1_valid_next     = 1'b0;
        s1_pair_next      = 1'b0;
        s1_conv_next      = 1'b0;
        s1_lead_next      = held_lead_reg;
        s1_byte_next      = data_byte;
        ram_rd_en         = 1'b0;
        if (accept && s_tuser == ACT_CONVERT) begin
            if (lead_pending_reg) begin
                // The trail is consumed with its lead whether or not it is valid.
                lead_pending_next = 1'b0;
                held_lead_next    = 8'd0;
                s1_valid_next     = 1'b1;
                s1_pair_next      = 1'b1;
                s1_conv_next      = pair_ok;
                ram_rd_en         = pair_ok;
            end else if (is_lead(direction_reg, data_byte) && !s_tlast) begin
                lead_pending_next = 1'b1;
                held_lead_next    = data_byte;
            end else begin
                s1_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg    <= DIR_GB_TO_BIG5;
            held_lead_reg    <= 8'd0;
            lead_pending_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                direction_reg <= cfg_wr_data;
            end
            held_lead_reg    <= held_lead_next;
            lead_pending_reg <= lead_pending_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_pair_reg <= s1_pair_next;
        s1_conv_reg <= s1_conv_next;
        s1_lead_reg <= s1_lead_next;
        s1_byte_reg <= s1_byte_next;
    end

    gbt_table_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_W'(table_index)),
        .wr_data (table_word),
        .rd_en   (ram_rd_en),
        .rd_addr (slot),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        push.cnt         = 2'd0;
        push.first.data  = s1_byte_reg;
        push.first.last  = 1'b1;
        push.second.data = s1_byte_reg;
        push.second.last = 1'b1;
        if (s1_valid_reg) begin
            if (s1_pair_reg) begin
                push.cnt         = 2'd2;
                push.first.data  = s1_conv_reg ? ram_rd_data[15:8] : s1_lead_reg;
                push.first.last  = 1'b0;
                push.second.data = s1_conv_reg ? ram_rd_data[7:0] : s1_byte_reg;
            end else begin
                push.cnt = 2'd1;
            end
        end
    end

    gbt_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .count    (fifo_count)
    );

endmodule

// File: sv/gbt_checker.sv
// Port-level checks of the transcoder's timing, bound to the top level.
// Depends only on the handshake and output ports of gb_big5_table_transcoder.
module gbt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // The output queue is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // When m_tvalid rises, its byte comes from an accepted beat that passed the table stage.
    a_out_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("output appeared without an input beat two cycles before");

    // With nothing queued the block must take input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output queue");

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

endmodule

bind gb_big5_table_transcoder gbt_checker u_gbt_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for gb_big5_table_transcoder: directed table rows, then
// random text streams in both directions under sender gaps and receiver stalls.
// Depends on gbt_pkg and the RTL; expected bytes come from a local model or typed rows.
module tb;
    import gbt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int GB_BASE        = BIG5_ENTRIES_DEF;

    typedef enum logic [1:0] {ROW_LOAD, ROW_CONV, ROW_DIR} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic        dir;
        logic [14:0] idx;
        logic [15:0] word;
        logic [7:0]  text;
        logic        eor;
        logic        by_model;  // checked against the local model, not typed bytes
        logic [1:0]  n;
        logic [7:0]  b0;
        logic [7:0]  b1;
    } stim_row_t;

    localparam int N_ROWS = 26;
    localparam stim_row_t DIRECTED [N_ROWS] = '{
        '{ROW_LOAD, 1'b0, 15'(GB_BASE), 16'hA140, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_LOAD, 1'b0, 15'(GB_BASE + 7613), 16'hF9FE, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00,
          8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'h00, 1'b0, 1'b0, 2'd1, 8'h00, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hFF, 1'b0, 1'b0, 2'd1, 8'hFF, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hA1, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hA1, 1'b0, 1'b0, 2'd2, 8'hA1, 8'h40},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hF7, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hFE, 1'b1, 1'b0, 2'd2, 8'hF9, 8'hFE},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hA1, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hA0, 1'b0, 1'b0, 2'd2, 8'hA1, 8'hA0},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hB0, 1'b1, 1'b0, 2'd1, 8'hB0, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hAA, 1'b0, 1'b0, 2'd1, 8'hAA, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hA1, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_LOAD, 1'b0, 15'(GB_BASE + 1), 16'h1234, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hA2, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hA1, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_LOAD, 1'b0, 15'd0, 16'hB0A1, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_DIR, DIR_BIG5_TO_GB, 15'd0, 16'h0000, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'h40, 1'b0, 1'b0, 2'd2, 8'hB0, 8'hA1},
        '{ROW_LOAD, 1'b0, 15'(BIG5_ENTRIES_DEF - 1), 16'hF7FE, 8'h00, 1'b0, 1'b0, 2'd0,
          8'h00, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hF9, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hFE, 1'b0, 1'b0, 2'd2, 8'hF7, 8'hFE},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hFA, 1'b0, 1'b0, 2'd1, 8'hFA, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'hF9, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_DIR, DIR_GB_TO_BIG5, 15'd0, 16'h0000, 8'h00, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00},
        '{ROW_CONV, 1'b0, 15'd0, 16'h0000, 8'h41, 1'b0, 1'b0, 2'd2, 8'hF9, 8'h41}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic                 cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 m_tlast;

    // Local model state.
    logic [15:0] code_mem [TABLE_DEPTH_DEF];
    bit          loaded [TABLE_DEPTH_DEF];
    logic        pred_dir;
    logic [7:0]  pred_held;
    logic        pred_pending;

    out_beat_t expected_bytes [$];
    int        byte_errors;
    int        beats_sent;
    int        quiet_cycles;
    int        tx_idle_pct;
    int        rx_stall_pct;
    bit        hold_req;
    bit        hold_ack;
    int        hold_left;

    gb_big5_table_transcoder u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic bit lead_byte_ok(input logic dir, input logic [7:0] c);
        if (dir == DIR_GB_TO_BIG5) begin
            return c inside {[GB_LEAD_LO:GB_LEAD_MID], [GB_LEAD_HANZI:GB_LEAD_HI]};
        end
        return c inside {[GB_LEAD_LO:BIG5_LEAD_HI]};
    endfunction

    // Table slot of a lead/trail pair; returns 0 when the pair passes through.
    function automatic bit pair_index(input logic dir, input logic [7:0] c1,
                                      input logic [7:0] c2, output int unsigned slot);
        int unsigned row, col, loc, base, span;
        row  = c1;
        col  = c2;
        slot = 0;
        loc  = 0;
        if (!lead_byte_ok(dir, c1)) begin
            return 1'b0;
        end
        if (dir == DIR_GB_TO_BIG5) begin
            if (col < TRAIL_LO || col == BYTE_INVALID) begin
                return 1'b0;
            end
            if (row <= GB_LEAD_MID) begin
                loc = (row - GB_LEAD_LO) * GB_ROW_LEN + (col - TRAIL_LO);
            end else begin
                loc = (row - GB_LEAD_HANZI + GB_ROW_SKIP) * GB_ROW_LEN + (col - TRAIL_LO);
            end
            base = GB_BASE;
            span = GB_ENTRIES_DEF;
        end else begin
            if (col >= BIG5_LOW_LO && col <= BIG5_LOW_HI) begin
                loc = (row - GB_LEAD_LO) * BIG5_ROW_LEN + (col - BIG5_LOW_LO);
            end else if (col >= TRAIL_LO && col != BYTE_INVALID) begin
                loc = (row - GB_LEAD_LO) * BIG5_ROW_LEN + (col - TRAIL_LO) + BIG5_HIGH_OFS;
            end else begin
                return 1'b0;
            end
            base = 0;
            span = BIG5_ENTRIES_DEF;
        end
        if (loc >= span || base + loc >= TABLE_DEPTH_DEF) begin
            return 1'b0;
        end
        slot = base + loc;
        return 1'b1;
    endfunction

    function automatic void predict_text_bytes(input logic act, input logic [14:0] idx,
                                               input logic [15:0] word, input logic [7:0] text,
                                               input logic eor, output int n,
                                               output logic [7:0] o0, output logic [7:0] o1);
        int unsigned slot;
        logic [15:0] w;
        n  = 0;
        o0 = 8'h00;
        o1 = 8'h00;
        if (act == ACT_LOAD) begin
            code_mem[idx] = word;
            loaded[idx]   = 1'b1;
        end else if (pred_pending) begin
            // The trail is consumed with the lead whether or not the pair converts.
            pred_pending = 1'b0;
            if (pair_index(pred_dir, pred_held, text, slot)) begin
                w  = code_mem[slot];
                o0 = w[15:8];
                o1 = w[7:0];
            end else begin
                o0 = pred_held;
                o1 = text;
            end
            n = 2;
        end else if (lead_byte_ok(pred_dir, text) && !eor) begin
            pred_held    = text;
            pred_pending = 1'b1;
        end else begin
            n  = 1;
            o0 = text;
        end
    endfunction

    // Offers one beat, waits for its handshake and queues the bytes it must produce.
    task automatic send_beat(input logic act, input logic [14:0] idx, input logic [15:0] word,
                             input logic [7:0] text, input logic eor, input bit typed,
                             input int tn, input logic [7:0] t0, input logic [7:0] t1);
        int n;
        logic [7:0] o0, o1;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tlast  <= eor;
        s_tdata  <= {1'b0, text, word, idx};
        do @(posedge aclk); while (!s_tready);
        predict_text_bytes(act, idx, word, text, eor, n, o0, o1);
        if (typed) begin
            n  = tn;
            o0 = t0;
            o1 = t1;
        end
        if (n == 1) begin
            expected_bytes.push_back('{data: o0, last: 1'b1});
        end else if (n == 2) begin
            expected_bytes.push_back('{data: o0, last: 1'b0});
            expected_bytes.push_back('{data: o1, last: 1'b1});
        end
        beats_sent++;
    endtask

    task automatic send_load(input logic [14:0] idx, input logic [15:0] word);
        send_beat(ACT_LOAD, idx, word, 8'($urandom), 1'($urandom), 1'b0, 0, 8'h00, 8'h00);
    endtask

    // A pair that would read a table slot never loaded gets its slot loaded first.
    task automatic send_text(input logic [7:0] text, input logic eor);
        int unsigned slot;
        if (pred_pending && pair_index(pred_dir, pred_held, text, slot) && !loaded[slot]) begin
            send_load(15'(slot), 16'($urandom));
        end
        send_beat(ACT_CONVERT, 15'($urandom), 16'($urandom), text, eor, 1'b0, 0, 8'h00, 8'h00);
    endtask

    task automatic set_direction(input logic dir);
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        // A held lead gives no byte, so let the pipeline settle before the write.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pred_dir = dir;
    endtask

    function automatic logic [7:0] rand_lead(input logic dir);
        int k;
        if (dir == DIR_BIG5_TO_GB) begin
            return 8'($urandom_range(GB_LEAD_LO, BIG5_LEAD_HI));
        end
        k = $urandom_range(0, 80);
        return (k < 9) ? 8'(GB_LEAD_LO + k) : 8'(GB_LEAD_HANZI + k - 9);
    endfunction

    function automatic logic [7:0] rand_trail(input logic dir);
        if (dir == DIR_BIG5_TO_GB && $urandom_range(0, 1) == 0) begin
            return 8'($urandom_range(BIG5_LOW_LO, BIG5_LOW_HI));
        end
        return 8'($urandom_range(TRAIL_LO, 8'hFE));
    endfunction

    function automatic logic [7:0] rand_bad_trail(input logic dir);
        int k;
        k = $urandom_range(0, 2);
        if (k == 0) begin
            return BYTE_INVALID;
        end
        if (dir == DIR_GB_TO_BIG5) begin
            return (k == 1) ? 8'hA0 : 8'($urandom_range(0, 8'hA0));
        end
        return (k == 1) ? 8'($urandom_range(0, 8'h3F)) : 8'($urandom_range(8'h7F, 8'hA0));
    endfunction

    task automatic random_burst();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_text(rand_lead(pred_dir), 1'b0);
            if ($urandom_range(0, 4) == 0) begin
                send_load(15'($urandom), 16'($urandom));
            end
            send_text(rand_trail(pred_dir), 1'($urandom));
        end else if (pick < 65) begin
            send_text(rand_lead(pred_dir), 1'b0);
            send_text(rand_bad_trail(pred_dir), 1'($urandom));
        end else if (pick < 72) begin
            send_text(rand_lead(pred_dir), 1'b1);
        end else if (pick < 85) begin
            send_text(8'($urandom_range(0, 8'h7F)), 1'($urandom));
        end else if (pick < 93) begin
            send_text(8'($urandom), 1'($urandom));
        end else begin
            send_load(15'($urandom), 16'($urandom));
        end
    endtask

    task automatic run_phase(input logic dir, input int tx_pct, input int rx_pct,
                             input bit hold, input int count);
        int target;
        set_direction(dir);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        if (hold) begin
            hold_req <= ~hold_req;
        end
        target = beats_sent + count;
        while (beats_sent < target) begin
            random_burst();
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: out beat %h last %b with nothing expected",
                             $time, m_tdata, m_tlast);
                    byte_errors++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data) begin
                        $display("%0t: out byte expected %h got %h", $time, want.data, m_tdata);
                        byte_errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: out last expected %b got %b", $time, want.last, m_tlast);
                        byte_errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("gb_big5_table_transcoder: mismatch");
                $finish;
            end
        end
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        pred_dir     = DIR_GB_TO_BIG5;
        pred_held    = 8'h00;
        pred_pending = 1'b0;
        byte_errors  = 0;
        beats_sent   = 0;
        quiet_cycles = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 1'b0;
        hold_ack     = 1'b0;
        hold_left    = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++) begin
            case (DIRECTED[i].kind)
                ROW_DIR: begin
                    set_direction(DIRECTED[i].dir);
                end
                ROW_LOAD: begin
                    send_beat(ACT_LOAD, DIRECTED[i].idx, DIRECTED[i].word, DIRECTED[i].text,
                              DIRECTED[i].eor, !DIRECTED[i].by_model, DIRECTED[i].n,
                              DIRECTED[i].b0, DIRECTED[i].b1);
                end
                default: begin
                    send_beat(ACT_CONVERT, DIRECTED[i].idx, DIRECTED[i].word,
                              DIRECTED[i].text, DIRECTED[i].eor, !DIRECTED[i].by_model,
                              DIRECTED[i].n, DIRECTED[i].b0, DIRECTED[i].b1);
                end
            endcase
        end

        run_phase(DIR_BIG5_TO_GB, 0, 0, 1'b0, 270);
        run_phase(DIR_GB_TO_BIG5, 68, 0, 1'b0, 270);
        run_phase(DIR_BIG5_TO_GB, 0, 68, 1'b0, 270);
        run_phase(DIR_GB_TO_BIG5, 14, 14, 1'b0, 270);
        // The sender keeps offering while the receiver holds off, so the queue fills.
        run_phase(DIR_GB_TO_BIG5, 0, 0, 1'b1, 270);
        run_phase(DIR_BIG5_TO_GB, 0, 0, 1'b0, 270);

        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (byte_errors == 0) begin
            $display("gb_big5_table_transcoder: match");
        end else begin
            $display("gb_big5_table_transcoder: mismatch");
        end
        $finish;
    end
endmodule
